// ===== hw/rtl/bpa_pkg.sv =====
// Shared types, constants and helper functions for the buddy page allocator.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package bpa_pkg;

  localparam int NUM_PAGES = 32768;
  localparam int TOP_ORDER = 14;
  localparam int NUM_ORD   = TOP_ORDER + 1;
  localparam int PAGE_W    = $clog2(NUM_PAGES);
  localparam int ORD_W     = $clog2(NUM_ORD);
  localparam int CNT_W     = 16;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_COUNT = 2'd1;
  localparam logic [1:0] ST_NO_BLOCK  = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    DP_IDLE,
    DP_LOAD,
    DP_ADD_PICK,
    DP_FIND,
    DP_SPLIT_PICK,
    DP_SPLIT_L,
    DP_SPLIT_R,
    DP_TAKE,
    DP_MERGE_BUD,
    DP_MERGE_UBASE,
    DP_MERGE_UBUD,
    DP_MERGE_UP,
    DP_UNLINK,
    DP_APPEND,
    DP_CLEAR
  } dp_op_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_ADD_PICK,
    S_FIND,
    S_SPLIT_CHK,
    S_SPLIT_L,
    S_SPLIT_R,
    S_TAKE_CHK,
    S_FIN_OK,
    S_FREE_RD,
    S_FREE_CHK,
    S_MERGE_CHK,
    S_MERGE_RD,
    S_MERGE_TEST,
    S_MERGE_UBUD,
    S_MERGE_UP,
    S_A_RD,
    S_A_UN,
    S_A_WR,
    S_U_RD,
    S_U_WR
  } state_t;

  typedef struct packed {
    logic       listed;
    logic [3:0] ord;
  } page_info_t;

  typedef struct packed {
    cmd_t cmd;
    logic bad;
    logic range_err;
    logic n_zero;
    logic found;
    logic split_more;
    logic li_empty;
    logic p_oob;
    logic rd_listed;
    logic merge_ok;
    logic bud_stop;
    logic clear_done;
  } dp_stat_t;

  function automatic logic [CNT_W-1:0] ord_pow(input logic [ORD_W-1:0] o);
    return CNT_W'(1) << o;
  endfunction

  // Largest order whose block fits in n, capped at the top order.
  function automatic logic [ORD_W-1:0] floor_ord(input logic [CNT_W-1:0] n);
    logic [ORD_W-1:0] r;
    r = '0;
    for (int i = 1; i <= TOP_ORDER; i++) begin
      if (n >= (CNT_W'(1) << i)) r = ORD_W'(i);
    end
    return r;
  endfunction

  // Smallest order whose block holds n pages, capped at the top order.
  function automatic logic [ORD_W-1:0] ceil_ord(input logic [CNT_W-1:0] n);
    logic [ORD_W-1:0] r;
    r = ORD_W'(TOP_ORDER);
    for (int i = TOP_ORDER; i >= 0; i--) begin
      if ((CNT_W'(1) << i) >= n) r = ORD_W'(i);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/bpa_datapath.sv =====
// Datapath of the buddy page allocator: page link memories, per-order lists
// and working registers. Depends on bpa_pkg; driven by bpa_controller.
`timescale 1ns / 1ps

module bpa_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  bpa_pkg::dp_op_t             op,
  input  logic [1:0]                  cmd_in,
  input  logic [bpa_pkg::PAGE_W-1:0]  page_in,
  input  logic [bpa_pkg::CNT_W-1:0]   count_in,
  input  logic                        cfg_we,
  input  logic [bpa_pkg::CNT_W-1:0]   cfg_data,
  output bpa_pkg::dp_stat_t           stat
);
  import bpa_pkg::*;

  logic [CNT_W-1:0]  total_pages;
  cmd_t              cmd_r;
  logic              err_bad;
  logic              err_range;
  logic [CNT_W-1:0]  base;
  logic [CNT_W-1:0]  n_r;
  logic [ORD_W-1:0]  ord;
  logic [ORD_W-1:0]  tgt;
  logic [CNT_W-1:0]  op_p;
  logic [ORD_W-1:0]  op_o;
  logic [PAGE_W-1:0] sp;
  logic [PAGE_W-1:0] clr;

  logic [PAGE_W-1:0] list_head  [NUM_ORD];
  logic [PAGE_W-1:0] list_tail  [NUM_ORD];
  logic [CNT_W-1:0]  list_count [NUM_ORD];

  page_info_t        info_mem [NUM_PAGES];
  logic [PAGE_W-1:0] next_mem [NUM_PAGES];
  logic [PAGE_W-1:0] prev_mem [NUM_PAGES];
  page_info_t        rd_info;
  logic [PAGE_W-1:0] rd_next;
  logic [PAGE_W-1:0] rd_prev;

  logic              info_we;
  logic [PAGE_W-1:0] info_wa;
  page_info_t        info_wd;
  logic              next_we;
  logic [PAGE_W-1:0] next_wa;
  logic [PAGE_W-1:0] next_wd;
  logic              prev_we;
  logic [PAGE_W-1:0] prev_wa;
  logic [PAGE_W-1:0] prev_wd;

  logic [CNT_W-1:0]  eff_total;
  logic [CNT_W:0]    range_sum;
  logic              in_zero;
  logic              in_big;
  logic              in_pow2;
  logic              in_bad;
  logic [ORD_W-1:0]  li;
  logic [ORD_W-1:0]  uo;
  logic [ORD_W-1:0]  pick_o;
  logic [ORD_W-1:0]  low_o;
  logic              found;
  logic [NUM_ORD-1:0] nonempty;
  logic [CNT_W-1:0]  bud;
  logic [CNT_W-1:0]  lo;
  logic [PAGE_W-1:0] cur_p;

  assign eff_total = (total_pages > CNT_W'(NUM_PAGES)) ? CNT_W'(NUM_PAGES) : total_pages;
  assign range_sum = {1'b0, CNT_W'(page_in)} + {1'b0, count_in};
  assign in_zero   = (count_in == '0);
  assign in_big    = (count_in > ord_pow(ORD_W'(TOP_ORDER)));
  assign in_pow2   = ((count_in & (count_in - CNT_W'(1))) == '0);
  assign pick_o    = floor_ord(n_r);
  assign bud       = base ^ ord_pow(ord);
  assign lo        = base & ~ord_pow(ord);
  assign cur_p     = op_p[PAGE_W-1:0];
  assign uo        = (rd_info.ord > 4'(TOP_ORDER)) ? ORD_W'(TOP_ORDER) : ORD_W'(rd_info.ord);

  always_comb begin
    unique case (cmd_t'(cmd_in))
      CMD_ADD:   in_bad = in_zero;
      CMD_ALLOC: in_bad = in_zero || in_big;
      CMD_FREE:  in_bad = in_zero || in_big || !in_pow2;
      default:   in_bad = 1'b1;
    endcase
  end

  always_comb begin
    for (int i = 0; i < NUM_ORD; i++) begin
      nonempty[i] = (list_count[i] != '0) && (ORD_W'(i) >= tgt);
    end
    found = |nonempty;
    low_o = '0;
    for (int i = NUM_ORD - 1; i >= 0; i--) begin
      if (nonempty[i]) low_o = ORD_W'(i);
    end
  end

  always_comb begin
    unique case (op)
      DP_UNLINK: li = uo;
      DP_APPEND: li = op_o;
      DP_TAKE:   li = tgt;
      default:   li = ord;
    endcase
  end

  always_comb begin
    info_we = 1'b0;
    info_wa = cur_p;
    info_wd = '{listed: 1'b0, ord: rd_info.ord};
    next_we = 1'b0;
    next_wa = rd_prev;
    next_wd = rd_next;
    prev_we = 1'b0;
    prev_wa = rd_next;
    prev_wd = rd_prev;
    unique case (op)
      DP_UNLINK: begin
        if (rd_info.listed) begin
          info_we = 1'b1;
          next_we = (list_head[li] != cur_p);
          prev_we = (list_tail[li] != cur_p);
        end
      end
      DP_APPEND: begin
        info_we = 1'b1;
        info_wd = '{listed: 1'b1, ord: 4'(op_o)};
        if (list_count[li] != '0) begin
          next_we = 1'b1;
          next_wa = list_tail[li];
          next_wd = cur_p;
          prev_we = 1'b1;
          prev_wa = cur_p;
          prev_wd = list_tail[li];
        end
      end
      DP_CLEAR: begin
        info_we = 1'b1;
        info_wa = clr;
        info_wd = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (info_we) info_mem[info_wa] <= info_wd;
    rd_info <= info_mem[cur_p];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    rd_next <= next_mem[cur_p];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    rd_prev <= prev_mem[cur_p];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_pages <= CNT_W'(NUM_PAGES);
      clr         <= '0;
      for (int i = 0; i < NUM_ORD; i++) begin
        list_count[i] <= '0;
        list_head[i]  <= '0;
        list_tail[i]  <= '0;
      end
    end else begin
      if (cfg_we) total_pages <= cfg_data;
      unique case (op)
        DP_CLEAR: clr <= clr + PAGE_W'(1);
        DP_UNLINK: begin
          if (rd_info.listed) begin
            if (list_head[li] == cur_p) list_head[li] <= rd_next;
            if (list_tail[li] == cur_p) list_tail[li] <= rd_prev;
            list_count[li] <= list_count[li] - CNT_W'(1);
          end
        end
        DP_APPEND: begin
          if (list_count[li] == '0) list_head[li] <= cur_p;
          list_tail[li]  <= cur_p;
          list_count[li] <= list_count[li] + CNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      DP_LOAD: begin
        cmd_r     <= cmd_t'(cmd_in);
        err_bad   <= in_bad;
        err_range <= (range_sum > {1'b0, eff_total}) && (cmd_t'(cmd_in) != CMD_ALLOC);
        base      <= CNT_W'(page_in);
        n_r       <= count_in;
        op_p      <= CNT_W'(page_in);
        tgt       <= ceil_ord(count_in);
        ord       <= floor_ord(count_in);
        op_o      <= floor_ord(count_in);
      end
      DP_ADD_PICK: begin
        op_p <= base;
        op_o <= pick_o;
        base <= base + ord_pow(pick_o);
        n_r  <= n_r - ord_pow(pick_o);
      end
      DP_FIND: ord <= low_o;
      DP_SPLIT_PICK: begin
        op_p <= CNT_W'(list_head[li]);
        sp   <= list_head[li];
        ord  <= ord - ORD_W'(1);
      end
      DP_SPLIT_L: begin
        op_p <= CNT_W'(sp);
        op_o <= ord;
      end
      DP_SPLIT_R: begin
        op_p <= CNT_W'(sp) + ord_pow(ord);
        op_o <= ord;
      end
      DP_TAKE: op_p <= CNT_W'(list_head[li]);
      DP_MERGE_BUD, DP_MERGE_UBUD: op_p <= bud;
      DP_MERGE_UBASE: op_p <= base;
      DP_MERGE_UP: begin
        base <= lo;
        op_p <= lo;
        ord  <= ord + ORD_W'(1);
        op_o <= ord + ORD_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign stat.cmd        = cmd_r;
  assign stat.bad        = err_bad;
  assign stat.range_err  = err_range;
  assign stat.n_zero     = (n_r == '0);
  assign stat.found      = found;
  assign stat.split_more = (ord > tgt);
  assign stat.li_empty   = (list_count[li] == '0);
  assign stat.p_oob      = (op_p >= CNT_W'(NUM_PAGES));
  assign stat.rd_listed  = rd_info.listed;
  assign stat.merge_ok   = rd_info.listed && (rd_info.ord == 4'(ord));
  assign stat.bud_stop   = (ord == ORD_W'(TOP_ORDER)) || (bud >= eff_total);
  assign stat.clear_done = (clr == PAGE_W'(NUM_PAGES - 1));

  a_unlink_nonempty: assert property (@(posedge clk) disable iff (rst)
    (op == DP_UNLINK && rd_info.listed) |-> (list_count[li] != '0))
    else $error("unlink of a listed page from an empty list");
  a_append_in_range: assert property (@(posedge clk) disable iff (rst)
    (op == DP_APPEND) |-> (op_p < CNT_W'(NUM_PAGES)))
    else $error("append of a page beyond the page memory");
  a_split_order: assert property (@(posedge clk) disable iff (rst)
    (op == DP_SPLIT_PICK) |-> (ord != '0 && list_count[li] != '0))
    else $error("split picked from an empty or bottom order");

endmodule

// ===== hw/rtl/bpa_controller.sv =====
// Controller state machine of the buddy page allocator: sequences list
// operations for add, allocate and free. Depends on bpa_pkg.
`timescale 1ns / 1ps

module bpa_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  bpa_pkg::dp_stat_t stat,
  output bpa_pkg::dp_op_t   op,
  output logic              busy,
  output logic              done,
  output logic [1:0]        status
);
  import bpa_pkg::*;

  state_t     state;
  state_t     state_next;
  state_t     ret;
  state_t     ret_next;
  logic       fin;
  logic [1:0] fin_code;

  always_comb begin
    state_next = state;
    ret_next   = ret;
    unique case (state)
      S_CLEAR:    if (stat.clear_done) state_next = S_IDLE;
      S_IDLE:     if (start) state_next = S_DISPATCH;
      S_DISPATCH: begin
        if (stat.bad || stat.range_err) begin
          state_next = S_IDLE;
        end else begin
          unique case (stat.cmd)
            CMD_ADD:   state_next = S_ADD_PICK;
            CMD_ALLOC: state_next = S_FIND;
            CMD_FREE:  state_next = S_FREE_RD;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_ADD_PICK: begin
        if (stat.n_zero) begin
          state_next = S_IDLE;
        end else begin
          ret_next   = S_ADD_PICK;
          state_next = S_A_RD;
        end
      end
      S_FIND:     state_next = stat.found ? S_SPLIT_CHK : S_IDLE;
      S_SPLIT_CHK: begin
        if (stat.split_more) begin
          ret_next   = S_SPLIT_L;
          state_next = S_U_RD;
        end else begin
          state_next = S_TAKE_CHK;
        end
      end
      S_SPLIT_L: begin
        ret_next   = S_SPLIT_R;
        state_next = S_A_RD;
      end
      S_SPLIT_R: begin
        ret_next   = S_SPLIT_CHK;
        state_next = S_A_RD;
      end
      S_TAKE_CHK: begin
        if (stat.li_empty) begin
          state_next = S_IDLE;
        end else begin
          ret_next   = S_FIN_OK;
          state_next = S_U_RD;
        end
      end
      S_FIN_OK:   state_next = S_IDLE;
      S_FREE_RD:  state_next = S_FREE_CHK;
      S_FREE_CHK: begin
        if (stat.rd_listed) begin
          state_next = S_IDLE;
        end else begin
          ret_next   = S_MERGE_CHK;
          state_next = S_A_RD;
        end
      end
      S_MERGE_CHK: state_next = stat.bud_stop ? S_IDLE : S_MERGE_RD;
      S_MERGE_RD:  state_next = S_MERGE_TEST;
      S_MERGE_TEST: begin
        if (!stat.merge_ok) begin
          state_next = S_IDLE;
        end else begin
          ret_next   = S_MERGE_UBUD;
          state_next = S_U_RD;
        end
      end
      S_MERGE_UBUD: begin
        ret_next   = S_MERGE_UP;
        state_next = S_U_RD;
      end
      S_MERGE_UP: begin
        ret_next   = S_MERGE_CHK;
        state_next = S_A_RD;
      end
      S_A_RD:  state_next = stat.p_oob ? ret : S_A_UN;
      S_A_UN:  state_next = S_A_WR;
      S_A_WR:  state_next = ret;
      S_U_RD:  state_next = S_U_WR;
      S_U_WR:  state_next = ret;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    op       = DP_IDLE;
    fin      = 1'b0;
    fin_code = ST_OK;
    unique case (state)
      S_CLEAR: op = DP_CLEAR;
      S_IDLE:  if (start) op = DP_LOAD;
      S_DISPATCH: begin
        if (stat.bad) begin
          fin      = 1'b1;
          fin_code = ST_BAD_COUNT;
        end else if (stat.range_err) begin
          fin      = 1'b1;
          fin_code = ST_RANGE;
        end else if (stat.cmd == CMD_RSVD) begin
          fin      = 1'b1;
          fin_code = ST_BAD_COUNT;
        end
      end
      S_ADD_PICK: begin
        if (stat.n_zero) fin = 1'b1;
        else op = DP_ADD_PICK;
      end
      S_FIND: begin
        op = DP_FIND;
        if (!stat.found) begin
          fin      = 1'b1;
          fin_code = ST_NO_BLOCK;
        end
      end
      S_SPLIT_CHK: if (stat.split_more) op = DP_SPLIT_PICK;
      S_SPLIT_L:   op = DP_SPLIT_L;
      S_SPLIT_R:   op = DP_SPLIT_R;
      S_TAKE_CHK: begin
        op = DP_TAKE;
        if (stat.li_empty) begin
          fin      = 1'b1;
          fin_code = ST_NO_BLOCK;
        end
      end
      S_FIN_OK: fin = 1'b1;
      S_FREE_CHK: begin
        if (stat.rd_listed) begin
          fin      = 1'b1;
          fin_code = ST_BAD_COUNT;
        end
      end
      S_MERGE_CHK: begin
        if (stat.bud_stop) fin = 1'b1;
        else op = DP_MERGE_BUD;
      end
      S_MERGE_TEST: begin
        if (!stat.merge_ok) fin = 1'b1;
        else op = DP_MERGE_UBASE;
      end
      S_MERGE_UBUD: op = DP_MERGE_UBUD;
      S_MERGE_UP:   op = DP_MERGE_UP;
      S_A_UN:       op = DP_UNLINK;
      S_A_WR:       op = DP_APPEND;
      S_U_WR:       op = DP_UNLINK;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ret   <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      done  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) status <= fin_code;
  end

  assign busy = (state != S_IDLE);

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result strobe outside the idle state");
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results in consecutive cycles");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_DISPATCH))
    else $error("accepted item did not reach dispatch");

endmodule

// ===== hw/rtl/buddy_page_allocator.sv =====
// Top level of the buddy page allocator: joins controller and datapath.
// Depends on bpa_pkg, bpa_controller and bpa_datapath.
`timescale 1ns / 1ps

// Usage:
// An item (command, page_index, count) is accepted on a clock edge where start
// is high and busy is low. Commands: add a free region, allocate, free a block.
// Exactly one result follows each item: status is valid for the single cycle in
// which done is high, and the receiver cannot hold it off.
// The total_pages register is written through cfg_valid/cfg_ready/total_pages;
// cfg_ready is always high, and writes are meant for idle periods.
// Steps: an item is loaded, then dispatched, where a rejected item ends. Each list
// append passes a read, an unlink and a write state, each removal a read and an
// unlink state, set by the registered read of the page link memories. Add appends
// one block per pick; allocate finds an order, removes one block and appends two
// halves per split, then removes the block; free appends, then merges buddies.
// Items are processed one at a time; busy stays high until the result shows.
// After reset, the block sweeps the page state memory once, one page a cycle,
// so busy stays high until every page is cleared, before the first item is taken.
// Configuration writes are taken during that sweep as well.
module buddy_page_allocator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 command,
  input  logic [bpa_pkg::PAGE_W-1:0] page_index,
  input  logic [bpa_pkg::CNT_W-1:0]  count,
  output logic                       done,
  output logic [1:0]                 status,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bpa_pkg::CNT_W-1:0]  total_pages
);
  import bpa_pkg::*;

  dp_op_t   op;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  bpa_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .stat   (stat),
    .op     (op),
    .busy   (busy),
    .done   (done),
    .status (status)
  );

  bpa_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .cmd_in   (command),
    .page_in  (page_index),
    .count_in (count),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (total_pages),
    .stat     (stat)
  );

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for buddy_page_allocator: add, allocate and free requests with
// random gaps, checked against a scoreboard that keeps its own copy of the free lists.
// Depends on bpa_pkg and the buddy_page_allocator RTL.
`timescale 1ns / 1ps

module tb;
  import bpa_pkg::*;

  class bpa_scoreboard;
    bit [14:0] nxt[NUM_PAGES];
    bit [14:0] prv[NUM_PAGES];
    bit [3:0]  pg_ord[NUM_PAGES];
    bit        listed[NUM_PAGES];
    bit [14:0] head[NUM_ORD];
    bit [14:0] tail[NUM_ORD];
    bit [15:0] ord_cnt[NUM_ORD];
    int unsigned total;
    logic [1:0] pending[$];
    int errors;
    int checked;

    function new();
      total = 32768;
      errors = 0;
      checked = 0;
    endfunction

    function int unsigned usable();
      return (total > NUM_PAGES) ? NUM_PAGES : total;
    endfunction

    function void unlink(int unsigned p);
      int unsigned o;
      bit [14:0] nx, pv;
      if (p >= NUM_PAGES || !listed[p]) return;
      o = pg_ord[p];
      nx = nxt[p];
      pv = prv[p];
      if (head[o] == p) head[o] = nx; else nxt[pv] = nx;
      if (tail[o] == p) tail[o] = pv; else prv[nx] = pv;
      ord_cnt[o] = ord_cnt[o] - 1;
      listed[p] = 0;
    endfunction

    function void append(int unsigned p, int unsigned o);
      if (p >= NUM_PAGES || o > TOP_ORDER) return;
      if (listed[p]) unlink(p);
      pg_ord[p] = o;
      if (ord_cnt[o] == 0) begin
        head[o] = p;
      end else begin
        nxt[tail[o]] = p;
        prv[p] = tail[o];
      end
      tail[o] = p;
      ord_cnt[o] = ord_cnt[o] + 1;
      listed[p] = 1;
    endfunction

    function logic [1:0] add_region(int unsigned base, int unsigned n);
      int unsigned o;
      if (n == 0) return ST_BAD_COUNT;
      if (base + n > usable()) return ST_RANGE;
      while (n > 0) begin
        o = 0;
        while (o < TOP_ORDER && (2 << o) <= n) o++;
        append(base, o);
        base += 1 << o;
        n -= 1 << o;
      end
      return ST_OK;
    endfunction

    function logic [1:0] take_block(int unsigned n, output int taken, output int unsigned t);
      int unsigned o, p;
      taken = -1;
      t = 0;
      if (n == 0 || n > (1 << TOP_ORDER)) return ST_BAD_COUNT;
      while ((1 << t) < n) t++;
      o = t;
      while (o <= TOP_ORDER && ord_cnt[o] == 0) o++;
      if (o > TOP_ORDER) return ST_NO_BLOCK;
      while (o > t) begin
        p = head[o];
        unlink(p);
        o--;
        append(p, o);
        append(p + (1 << o), o);
      end
      if (ord_cnt[t] == 0) return ST_NO_BLOCK;
      taken = head[t];
      unlink(head[t]);
      return ST_OK;
    endfunction

    function logic [1:0] release_block(int unsigned base, int unsigned n);
      int unsigned o, bud, lo;
      o = 0;
      if (n == 0 || n > (1 << TOP_ORDER) || (n & (n - 1)) != 0) return ST_BAD_COUNT;
      if (base + n > usable()) return ST_RANGE;
      if (listed[base]) return ST_BAD_COUNT;
      while ((1 << o) < n) o++;
      append(base, o);
      while (o < TOP_ORDER) begin
        bud = base ^ (1 << o);
        if (bud >= usable()) break;
        if (!listed[bud] || pg_ord[bud] != o) break;
        unlink(base);
        unlink(bud);
        lo = (base < bud) ? base : bud;
        o++;
        append(lo, o);
        base = lo;
      end
      return ST_OK;
    endfunction

    function void note_request(cmd_t c, int unsigned idx, int unsigned n,
                               output int taken, output int unsigned t);
      logic [1:0] st;
      taken = -1;
      t = 0;
      case (c)
        CMD_ADD:   st = add_region(idx, n);
        CMD_ALLOC: st = take_block(n, taken, t);
        CMD_FREE:  st = release_block(idx, n);
        default:   st = ST_BAD_COUNT;
      endcase
      pending.push_back(st);
    endfunction

    function void check_status(logic [1:0] st);
      logic [1:0] want;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: status %0d with no request outstanding", $time, st);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (st !== want) begin
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, want, st);
        errors++;
      end
    endfunction
  endclass

  localparam int LIMIT = 3000000;

  typedef struct {
    int unsigned page;
    int unsigned ord;
  } blk_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  command;
  logic [14:0] page_index;
  logic [15:0] count;
  logic        done;
  logic [1:0]  status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] total_pages;

  bpa_scoreboard sb;
  blk_t owned[$];
  int cycles;
  int sent;
  bit no_gaps;

  buddy_page_allocator u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .page_index(page_index),
    .count(count),
    .done(done),
    .status(status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .total_pages(total_pages)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_status(status);
  end

  task automatic issue(input cmd_t c, input int unsigned idx, input int unsigned n);
    int gap;
    int taken;
    int unsigned t;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    command <= c;
    page_index <= idx[14:0];
    count <= n[15:0];
    do @(posedge clk); while (busy);
    sb.note_request(c, idx[14:0], n[15:0], taken, t);
    sent++;
    if (taken >= 0) owned.push_back('{page: taken, ord: t});
  endtask

  task automatic quiesce();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_total(input int unsigned v);
    cfg_valid <= 1'b1;
    total_pages <= v[15:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.total = v[15:0];
  endtask

  task automatic free_owned();
    int k;
    blk_t b;
    k = $urandom_range(0, owned.size() - 1);
    b = owned[k];
    owned.delete(k);
    issue(CMD_FREE, b.page, 1 << b.ord);
  endtask

  task automatic random_item();
    int sel;
    int unsigned n, lim;
    sel = $urandom_range(0, 99);
    lim = sb.usable();
    if (sel < 15) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, lim) : $urandom_range(1, 200);
      issue(CMD_ADD, $urandom_range(0, lim - 1), n);
    end else if (sel < 50) begin
      if ($urandom_range(0, 39) == 0) n = $urandom_range(0, 65535);
      else if ($urandom_range(0, 9) == 0) n = $urandom_range(1, 16384);
      else n = $urandom_range(1, 64);
      issue(CMD_ALLOC, $urandom, n);
    end else if (sel < 85 && owned.size() > 0) begin
      free_owned();
    end else begin
      issue(cmd_t'($urandom_range(0, 3)), $urandom, $urandom_range(0, 65535));
    end
  endtask

  initial begin
    int unsigned totals[5] = '{16'd1, 16'd65535, 16'd300, 16'd4097, 16'd32768};
    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    command = CMD_ADD;
    page_index = '0;
    count = '0;
    cfg_valid = 1'b0;
    total_pages = 16'd32768;
    cycles = 0;
    sent = 0;
    no_gaps = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    set_total(32768);

    issue(CMD_ADD, 5, 0);
    issue(CMD_ALLOC, 0, 0);
    issue(CMD_FREE, 5, 0);
    issue(CMD_RSVD, 32767, 65535);
    issue(CMD_ADD, 0, 32768);
    issue(CMD_ADD, 1, 32768);
    issue(CMD_ALLOC, 0, 16385);
    issue(CMD_ALLOC, 0, 65535);
    issue(CMD_ALLOC, 0, 16384);
    issue(CMD_ALLOC, 0, 1);
    issue(CMD_ALLOC, 0, 3);
    issue(CMD_FREE, 8, 3);
    issue(CMD_FREE, 0, 65535);
    issue(CMD_FREE, 32767, 2);
    issue(CMD_FREE, 32767, 1);
    issue(CMD_FREE, 32767, 1);
    issue(CMD_ADD, 100, 77);
    issue(CMD_ADD, 32767, 1);
    while (owned.size() > 0) free_owned();
    issue(CMD_ALLOC, 0, 16384);
    issue(CMD_ALLOC, 0, 16384);
    issue(CMD_ALLOC, 0, 16384);
    quiesce();

    foreach (totals[i]) begin
      set_total(totals[i]);
      for (int j = 0; j < 360; j++) begin
        no_gaps = (j >= 100 && j < 160);
        if (j == 200) quiesce();
        random_item();
      end
      quiesce();
    end

    $display("Checked %0d status results over %0d requests and five page limits.",
             sb.checked, sent);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
